// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk_i edge outside reset.
`define CRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clk_i edge, reset included.
`define CRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hdl/crp_pkg.sv
package crp_pkg;

  localparam int MAX_WAYPOINTS_DEF = 16;

  localparam int CompW = 32;
  localparam int TimeW = 32;
  localparam int StepW = 31;
  localparam int CountW = 5;
  localparam int SlotW = 4;
  localparam int MuW = 17;
  localparam int AccW = 38;

  localparam logic [CountW-1:0] COUNT_RST = 5'd4;
  localparam logic [StepW-1:0] DUR_RST = 31'd65536;
  localparam logic [MuW-1:0] MU_ONE = 17'd65536;

  localparam logic [1:0] CFG_COUNT = 2'd0;
  localparam logic [1:0] CFG_DURATION = 2'd1;
  localparam logic [1:0] CFG_ENABLE = 2'd2;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic signed [CompW-1:0] x;
    logic signed [CompW-1:0] y;
    logic signed [CompW-1:0] z;
    logic signed [CompW-1:0] w;
  } wp_t;

endpackage

// File: hdl/crp_ifs.sv
interface crp_in_if;
  import crp_pkg::*;
  logic valid;
  logic ready;
  logic func;
  logic [SlotW-1:0] waypoint_slot;
  logic signed [CompW-1:0] load_x;
  logic signed [CompW-1:0] load_y;
  logic signed [CompW-1:0] load_z;
  logic signed [CompW-1:0] load_w;
  logic [StepW-1:0] time_step;
  modport source (output valid, func, waypoint_slot, load_x, load_y, load_z, load_w,
                  time_step, input ready);
  modport sink (input valid, func, waypoint_slot, load_x, load_y, load_z, load_w,
                time_step, output ready);
endinterface

interface crp_out_if;
  import crp_pkg::*;
  logic valid;
  logic ready;
  logic signed [CompW-1:0] pos_x;
  logic signed [CompW-1:0] pos_y;
  logic signed [CompW-1:0] pos_z;
  logic signed [CompW-1:0] pos_w;
  logic [SlotW-1:0] segment_now;
  modport source (output valid, pos_x, pos_y, pos_z, pos_w, segment_now, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, pos_w, segment_now, output ready);
endinterface

interface crp_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/crp_wp_mem.sv
module crp_wp_mem #(
  parameter int MaxWaypoints = crp_pkg::MAX_WAYPOINTS_DEF,
  localparam int AddrW = $clog2(MaxWaypoints)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  crp_pkg::wp_t     wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output crp_pkg::wp_t     rdata_o
);
  import crp_pkg::*;

  wp_t mem_q [MaxWaypoints];
  wp_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: hdl/crp_mu_div.sv
// mu = floor(num * 2^16 / den), or 2^16 when num is at or above den; restoring, one quotient bit per cycle.
module crp_mu_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [crp_pkg::TimeW-1:0]  num_i,
  input  logic [crp_pkg::StepW-1:0]  den_i,
  output logic                       done_o,
  output logic [crp_pkg::MuW-1:0]    mu_o
);
  import crp_pkg::*;

  logic [StepW-1:0] rem_q, rem_d;
  logic [StepW-1:0] den_q, den_d;
  logic [MuW-1:0] mu_q, mu_d;
  logic [4:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic done_q, done_d;
  logic [StepW:0] rem2;

  always_comb begin
    rem_d = rem_q;
    den_d = den_q;
    mu_d = mu_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem2 = {rem_q, 1'b0};
    if (start_i) begin
      den_d = den_i;
      if (num_i >= {1'b0, den_i}) begin
        mu_d = MU_ONE;
        done_d = 1'b1;
      end else begin
        rem_d = num_i[StepW-1:0];
        mu_d = '0;
        cnt_d = 5'd16;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (rem2 >= {1'b0, den_q}) begin
        rem_d = StepW'(rem2 - {1'b0, den_q});
        mu_d = {mu_q[MuW-2:0], 1'b1};
      end else begin
        rem_d = rem2[StepW-1:0];
        mu_d = {mu_q[MuW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    mu_q <= mu_d;
  end

  assign done_o = done_q;
  assign mu_o = mu_q;
endmodule

// File: hdl/crp_horner.sv
// One component: Horner on doubled coefficients with a single shared multiplier.
module crp_horner (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [crp_pkg::CompW-1:0] p0_i,
  input  logic signed [crp_pkg::CompW-1:0] p1_i,
  input  logic signed [crp_pkg::CompW-1:0] p2_i,
  input  logic signed [crp_pkg::CompW-1:0] p3_i,
  input  logic [crp_pkg::MuW-1:0]          mu_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic signed [crp_pkg::CompW-1:0] res_o
);
  import crp_pkg::*;

  typedef enum logic [1:0] {HZ_IDLE, HZ_MUL, HZ_ADD} hz_state_e;

  localparam int ProdW = AccW + MuW + 1;

  hz_state_e state_q;
  logic [1:0] step_q;
  logic done_q;
  logic signed [AccW-1:0] t_q, b_q, c_q, d_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [CompW-1:0] res_q;
  logic signed [AccW-1:0] e0, e1, e2, e3;
  logic signed [AccW-1:0] coef_a, coef_b, coef_c;
  logic signed [AccW-1:0] addend, t_next, half;

  assign e0 = AccW'(p0_i);
  assign e1 = AccW'(p1_i);
  assign e2 = AccW'(p2_i);
  assign e3 = AccW'(p3_i);
  assign coef_a = e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
  assign coef_b = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
  assign coef_c = e2 - e0;

  always_comb begin
    case (step_q)
      2'd0:    addend = b_q;
      2'd1:    addend = c_q;
      default: addend = d_q;
    endcase
  end

  assign t_next = AccW'(prod_q >>> 16) + addend;
  assign half = t_next >>> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HZ_IDLE;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        HZ_IDLE: begin
          if (start_i) begin
            state_q <= HZ_MUL;
            step_q <= '0;
          end
        end
        HZ_MUL: state_q <= HZ_ADD;
        HZ_ADD: begin
          if (step_q == 2'd2) begin
            state_q <= HZ_IDLE;
            done_q <= 1'b1;
          end else begin
            state_q <= HZ_MUL;
            step_q <= step_q + 2'd1;
          end
        end
        default: state_q <= HZ_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == HZ_IDLE && start_i) begin
      t_q <= coef_a;
      b_q <= coef_b;
      c_q <= coef_c;
      d_q <= e1 <<< 1;
    end
    if (state_q == HZ_MUL) begin
      prod_q <= ProdW'(t_q) * ProdW'(signed'({1'b0, mu_i}));
    end
    if (state_q == HZ_ADD) begin
      t_q <= t_next;
      if (half > AccW'(64'sh7FFFFFFF)) begin
        res_q <= 32'sh7FFFFFFF;
      end else if (half < -AccW'(64'sh80000000)) begin
        res_q <= 32'sh80000000;
      end else begin
        res_q <= half[CompW-1:0];
      end
    end
  end

  assign busy_o = (state_q != HZ_IDLE);
  assign done_o = done_q;
  assign res_o = res_q;
endmodule

// File: hdl/catmull_rom_path_follower_top.sv
// Closed-path Catmull-Rom follower. Load transfers (func=0) write one waypoint in the
// accepting cycle. A tick transfer (func=1, animation enabled) runs these steps after its
// accepting cycle until the position is valid. First the segment index is reduced modulo
// the count (one subtract per cycle). Then the four waypoints are read from the waypoint
// RAM. mu is one when the time is at or past the duration, else it comes from the
// bit-serial divider. Then the four components are evaluated in turn on the one shared
// multiplier. Last, the output register is loaded. Input is held off for the whole tick.
// A full output register stalls the tick in its last step. The next item is accepted the
// cycle after the output register loads, while that position may still wait there.
// Disabled ticks are accepted and give no result.
`include "assert_macros.svh"

module catmull_rom_path_follower_top #(
  parameter int MaxWaypoints = crp_pkg::MAX_WAYPOINTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  crp_in_if.sink    in_i,
  crp_out_if.source out_o,
  crp_cfg_if.sink   cfg_i
);
  import crp_pkg::*;

  localparam int AddrW = $clog2(MaxWaypoints);

  typedef enum logic [2:0] {ST_IDLE, ST_MOD, ST_READ, ST_DIV, ST_CALC, ST_DONE} state_e;

  state_e state_q;

  // configuration
  logic [CountW-1:0] cnt_q;
  logic [StepW-1:0] dur_q;
  logic en_q;

  // follower state
  logic [TimeW-1:0] seg_time_q;
  logic [SlotW-1:0] seg_idx_q;

  // per-tick work registers
  logic [CountW-1:0] ce_q, cnt_eff;
  logic [StepW-1:0] de_q, dur_eff;
  logic [StepW-1:0] step_q;
  logic [CountW-1:0] i0_q, rd_idx_q, rd_nxt;
  logic [2:0] rd_n_q;
  logic [1:0] comp_q;
  logic hz_start_q;
  wp_t pw_q [4];
  logic signed [CompW-1:0] res_q [4];

  // output register
  logic out_vld_q;
  logic signed [CompW-1:0] ox_q, oy_q, oz_q, ow_q;
  logic [SlotW-1:0] oseg_q;

  logic in_fire, cfg_fire, out_fire;
  logic mem_we;
  wp_t mem_wdata, mem_rdata;
  logic div_start, div_done;
  logic [MuW-1:0] mu;
  logic hz_busy, hz_done;
  logic signed [CompW-1:0] hz_res;
  logic signed [CompW-1:0] hp0, hp1, hp2, hp3;
  logic [TimeW:0] sum;
  logic [TimeW-1:0] sum_sat;
  logic [CountW-1:0] i0_inc;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire = cfg_i.valid;
  assign out_fire = out_vld_q && out_o.ready;

  // count of zero acts as one, above the table depth acts as the depth
  always_comb begin
    if (cnt_q == '0) begin
      cnt_eff = CountW'(1);
    end else if (int'(cnt_q) > MaxWaypoints) begin
      cnt_eff = CountW'(MaxWaypoints);
    end else begin
      cnt_eff = cnt_q;
    end
    dur_eff = (dur_q == '0) ? StepW'(1) : dur_q;
  end

  assign mem_we = in_fire && (in_i.func == FUNC_LOAD) &&
                  (int'(in_i.waypoint_slot) < MaxWaypoints);
  assign mem_wdata = '{x: in_i.load_x, y: in_i.load_y, z: in_i.load_z, w: in_i.load_w};

  crp_wp_mem #(.MaxWaypoints(MaxWaypoints)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AddrW'(in_i.waypoint_slot)),
    .wdata_i (mem_wdata),
    .raddr_i (AddrW'(rd_idx_q)),
    .rdata_o (mem_rdata)
  );

  // next waypoint index around the closed path
  assign rd_nxt = (rd_idx_q + CountW'(1) == ce_q) ? '0 : rd_idx_q + CountW'(1);
  assign i0_inc = (i0_q + CountW'(1) == ce_q) ? '0 : i0_q + CountW'(1);

  assign div_start = (state_q == ST_READ) && (rd_n_q == 3'd4);

  crp_mu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (seg_time_q),
    .den_i   (de_q),
    .done_o  (div_done),
    .mu_o    (mu)
  );

  always_comb begin
    case (comp_q)
      2'd0: begin
        hp0 = pw_q[0].x; hp1 = pw_q[1].x; hp2 = pw_q[2].x; hp3 = pw_q[3].x;
      end
      2'd1: begin
        hp0 = pw_q[0].y; hp1 = pw_q[1].y; hp2 = pw_q[2].y; hp3 = pw_q[3].y;
      end
      2'd2: begin
        hp0 = pw_q[0].z; hp1 = pw_q[1].z; hp2 = pw_q[2].z; hp3 = pw_q[3].z;
      end
      default: begin
        hp0 = pw_q[0].w; hp1 = pw_q[1].w; hp2 = pw_q[2].w; hp3 = pw_q[3].w;
      end
    endcase
  end

  crp_horner u_hz (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hz_start_q),
    .p0_i    (hp0),
    .p1_i    (hp1),
    .p2_i    (hp2),
    .p3_i    (hp3),
    .mu_i    (mu),
    .busy_o  (hz_busy),
    .done_o  (hz_done),
    .res_o   (hz_res)
  );

  // segment time advance, saturating at the top of the range
  assign sum = {1'b0, seg_time_q} + (TimeW+1)'(step_q);
  assign sum_sat = sum[TimeW] ? '1 : sum[TimeW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= COUNT_RST;
      dur_q <= DUR_RST;
      en_q <= 1'b1;
      seg_time_q <= '0;
      seg_idx_q <= '0;
      out_vld_q <= 1'b0;
      hz_start_q <= 1'b0;
      rd_n_q <= '0;
      comp_q <= '0;
    end else begin
      hz_start_q <= 1'b0;
      // in ST_DONE the output register is reloaded instead
      if (out_fire && state_q != ST_DONE) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_fire) begin
        unique case (cfg_i.index)
          CFG_COUNT:    cnt_q <= cfg_i.data[CountW-1:0];
          CFG_DURATION: dur_q <= cfg_i.data[StepW-1:0];
          CFG_ENABLE:   en_q <= cfg_i.data[0];
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && in_i.func == FUNC_TICK && en_q) begin
            i0_q <= {1'b0, seg_idx_q};
            state_q <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (i0_q >= ce_q) begin
            i0_q <= i0_q - ce_q;
          end else begin
            rd_idx_q <= i0_q;
            rd_n_q <= '0;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          // address goes out the cycle before its data returns
          if (rd_n_q != 3'd0) begin
            pw_q[rd_n_q[1:0] - 2'd1] <= mem_rdata;
          end
          rd_idx_q <= rd_nxt;
          rd_n_q <= rd_n_q + 3'd1;
          if (rd_n_q == 3'd4) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            comp_q <= '0;
            hz_start_q <= 1'b1;
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (hz_done) begin
            res_q[comp_q] <= hz_res;
            if (comp_q == 2'd3) begin
              state_q <= ST_DONE;
            end else begin
              comp_q <= comp_q + 2'd1;
              hz_start_q <= 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (!out_vld_q || out_o.ready) begin
            out_vld_q <= 1'b1;
            ox_q <= res_q[0];
            oy_q <= res_q[1];
            oz_q <= res_q[2];
            ow_q <= res_q[3];
            oseg_q <= i0_q[SlotW-1:0];
            if (sum_sat >= TimeW'(de_q)) begin
              seg_time_q <= sum_sat - TimeW'(de_q);
              seg_idx_q <= i0_inc[SlotW-1:0];
            end else begin
              seg_time_q <= sum_sat;
              seg_idx_q <= i0_q[SlotW-1:0];
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // tick snapshot; no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.func == FUNC_TICK) begin
      step_q <= in_i.time_step;
      ce_q <= cnt_eff;
      de_q <= dur_eff;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.pos_x = ox_q;
  assign out_o.pos_y = oy_q;
  assign out_o.pos_z = oz_q;
  assign out_o.pos_w = ow_q;
  assign out_o.segment_now = oseg_q;

  `CRP_ASSERT(a_idx_reduced, (state_q == ST_READ) |-> (i0_q < ce_q), "segment index not reduced")
  `CRP_ASSERT(a_mu_range, (state_q == ST_CALC) |-> (mu <= MU_ONE), "mu above one")
  `CRP_ASSERT(a_done_loads, (state_q == ST_DONE && !out_vld_q) |=> out_vld_q,
              "finished tick not presented")
  `CRP_ASSERT_ALWAYS(a_hz_idle, (state_q != ST_CALC) |-> !hz_busy, "multiplier busy outside calc")
endmodule

// File: test/tb_crp_scoreboard.sv
`timescale 1ns / 1ps

// Expected-position store and Catmull-Rom path predictor.
class crp_path_scoreboard;
  logic signed [31:0] wp_x[16], wp_y[16], wp_z[16], wp_w[16];
  bit [31:0] seg_time;
  bit [3:0] seg_idx;
  bit [4:0] wp_count;
  bit [30:0] seg_dur;
  bit anim_en;

  bit [131:0] pos_queue[$];
  int unsigned n_errors;

  function void reset_state();
    seg_time = 0;
    seg_idx = 0;
    wp_count = 5'd4;
    seg_dur = 31'd65536;
    anim_en = 1'b1;
    pos_queue.delete();
    n_errors = 0;
    for (int i = 0; i < 16; i++) begin
      wp_x[i] = 0; wp_y[i] = 0; wp_z[i] = 0; wp_w[i] = 0;
    end
  endfunction

  function void write_reg(bit [1:0] idx, bit [31:0] val);
    if (idx == crp_pkg::CFG_COUNT) wp_count = val[4:0];
    else if (idx == crp_pkg::CFG_DURATION) seg_dur = val[30:0];
    else if (idx == crp_pkg::CFG_ENABLE) anim_en = val[0];
  endfunction

  static function longint floor16(longint v);
    if (v >= 0) return v / 65536;
    return -(((-v) + 65535) / 65536);
  endfunction

  static function bit [31:0] cubic_eval(longint p0, longint p1, longint p2, longint p3,
                                        longint mu);
    longint a, b, c, t;
    a = -p0 + 3 * p1 - 3 * p2 + p3;
    b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c = -p0 + p2;
    t = floor16(a * mu) + b;
    t = floor16(t * mu) + c;
    t = floor16(t * mu) + 2 * p1;
    t = (t >= 0) ? t / 2 : -(((-t) + 1) / 2);
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return t[31:0];
  endfunction

  // Notes one accepted input transfer.
  function void note_input(bit func, bit [3:0] slot, bit [31:0] x, bit [31:0] y,
                           bit [31:0] z, bit [31:0] w, bit [30:0] step);
    int cnt, i0, i1, i2, i3;
    longint mu, dur;
    longint unsigned sum;
    bit [131:0] e;
    if (func == crp_pkg::FUNC_LOAD) begin
      wp_x[slot] = x; wp_y[slot] = y; wp_z[slot] = z; wp_w[slot] = w;
      return;
    end
    if (!anim_en) return;
    cnt = (wp_count < 1) ? 1 : (wp_count > 16) ? 16 : wp_count;
    dur = (seg_dur == 0) ? 1 : seg_dur;
    i0 = seg_idx % cnt; i1 = (i0 + 1) % cnt; i2 = (i0 + 2) % cnt; i3 = (i0 + 3) % cnt;
    mu = (seg_time >= dur) ? 65536 : ((longint'(seg_time) << 16) / dur);
    e[131:100] = cubic_eval(wp_x[i0], wp_x[i1], wp_x[i2], wp_x[i3], mu);
    e[99:68] = cubic_eval(wp_y[i0], wp_y[i1], wp_y[i2], wp_y[i3], mu);
    e[67:36] = cubic_eval(wp_z[i0], wp_z[i1], wp_z[i2], wp_z[i3], mu);
    e[35:4] = cubic_eval(wp_w[i0], wp_w[i1], wp_w[i2], wp_w[i3], mu);
    e[3:0] = i0[3:0];
    pos_queue.push_back(e);
    sum = longint'(seg_time) + step;
    if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
    seg_time = sum[31:0];
    if (seg_time >= dur) begin
      seg_time = seg_time - dur[31:0];
      seg_idx = i1[3:0];
    end else begin
      seg_idx = i0[3:0];
    end
  endfunction

  // Checks one accepted position transfer against the oldest expectation.
  function void check_position(bit [31:0] x, bit [31:0] y, bit [31:0] z, bit [31:0] w,
                               bit [3:0] seg);
    bit [131:0] e;
    if (pos_queue.size() == 0) begin
      $display("%0t: unexpected position x=%h y=%h z=%h w=%h seg=%0d", $time, x, y, z, w,
               seg);
      n_errors++;
      return;
    end
    e = pos_queue.pop_front();
    if (e[131:100] !== x) begin
      $display("%0t: pos_x expected %h actual %h", $time, e[131:100], x); n_errors++;
    end
    if (e[99:68] !== y) begin
      $display("%0t: pos_y expected %h actual %h", $time, e[99:68], y); n_errors++;
    end
    if (e[67:36] !== z) begin
      $display("%0t: pos_z expected %h actual %h", $time, e[67:36], z); n_errors++;
    end
    if (e[35:4] !== w) begin
      $display("%0t: pos_w expected %h actual %h", $time, e[35:4], w); n_errors++;
    end
    if (e[3:0] !== seg) begin
      $display("%0t: segment_now expected %0d actual %0d", $time, e[3:0], seg); n_errors++;
    end
  endfunction
endclass

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import crp_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  crp_in_if in_ch();
  crp_out_if out_ch();
  crp_cfg_if cfg_ch();

  catmull_rom_path_follower_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_i(cfg_ch.sink)
  );

  always #1 clk_i = ~clk_i;

  crp_path_scoreboard path_sb = new();

  // Idle control for both sides.
  bit no_idle;        // long stretch with no gaps on either side
  bit hold_off;       // receiver held off while the sender keeps pushing
  bit sink_go;

  // Waypoints actually written so far; ticks only run over written slots.
  bit [15:0] written;

  initial begin
    in_ch.valid = 1'b0; in_ch.func = FUNC_LOAD; in_ch.waypoint_slot = '0;
    in_ch.load_x = '0; in_ch.load_y = '0; in_ch.load_z = '0; in_ch.load_w = '0;
    in_ch.time_step = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = CFG_COUNT; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver: random stalls, or held off entirely during the pressure window.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && (no_idle || ($urandom_range(99) >= 27));
    end
  end

  // Result monitor: transfers are sampled at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      path_sb.check_position(out_ch.pos_x, out_ch.pos_y, out_ch.pos_z, out_ch.pos_w,
                             out_ch.segment_now);
    end
  end

  // Offers one item and waits for its transfer; the prediction is noted at acceptance.
  // Drives are blocking so back-to-back items may drop and raise valid at one falling edge.
  task automatic send_item(bit func, bit [3:0] slot, bit [31:0] x, bit [31:0] y,
                           bit [31:0] z, bit [31:0] w, bit [30:0] step);
    while (!no_idle && $urandom_range(99) < 27) @(negedge clk_i);
    in_ch.valid = 1'b1; in_ch.func = func; in_ch.waypoint_slot = slot;
    in_ch.load_x = x; in_ch.load_y = y; in_ch.load_z = z; in_ch.load_w = w;
    in_ch.time_step = step;
    do @(posedge clk_i); while (!in_ch.ready);
    path_sb.note_input(func, slot, x, y, z, w, step);
    if (func == FUNC_LOAD) written[slot] = 1'b1;
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  task automatic load_point(bit [3:0] slot, bit [31:0] x, bit [31:0] y, bit [31:0] z,
                            bit [31:0] w);
    send_item(FUNC_LOAD, slot, x, y, z, w, 31'($urandom));
  endtask

  // Tick with random load fields so that those bits toggle on ticks too.
  task automatic tick(bit [30:0] step);
    send_item(FUNC_TICK, 4'($urandom), $urandom, $urandom, $urandom, $urandom, step);
  endtask

  // Waits until every predicted position came out, then lets a late tick settle.
  task automatic drain();
    int guard;
    guard = 0;
    while (path_sb.pos_queue.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [31:0] val);
    drain();
    cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    path_sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random Q16.16 component, biased toward extremes now and then.
  function automatic bit [31:0] rand_comp();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic bit [30:0] rand_step();
    case ($urandom_range(7))
      0: return 31'h7FFF_FFFF;
      1: return 31'd0;
      2: return 31'($urandom_range(200000));
      default: return 31'($urandom_range(40000));
    endcase
  endfunction

  // Fills all 16 slots so no unwritten entry can ever be read.
  task automatic fill_table();
    for (int s = 0; s < 16; s++) load_point(s[3:0], rand_comp(), rand_comp(), rand_comp(),
                                             rand_comp());
  endtask

  initial begin
    int counts[6];
    written = '0;
    no_idle = 1'b0;
    hold_off = 1'b0;
    path_sb.reset_state();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: table at component extremes, then ticks on reset settings.
    load_point(4'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    load_point(4'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_0001);
    load_point(4'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 32'h5555_5555);
    load_point(4'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_8000, 32'hAAAA_AAAA);
    tick(31'd0);
    tick(31'd32768);
    tick(31'd32768);          // reaches duration: next segment
    tick(31'h7FFF_FFFF);      // far past duration: mu saturates next tick
    tick(31'h7FFF_FFFF);      // far past duration again: next segment
    tick(31'd1);
    fill_table();

    // Single waypoint, zero duration, disabled ticks, count above the table size.
    write_reg(CFG_COUNT, 32'd0);
    write_reg(CFG_DURATION, 32'd0);
    tick(31'd0); tick(31'd1); tick(31'd5);
    write_reg(CFG_ENABLE, 32'd0);
    tick(31'd100); tick(31'd7);
    write_reg(CFG_ENABLE, 32'd1);
    write_reg(CFG_COUNT, 32'd31);
    write_reg(CFG_DURATION, 32'h7FFF_FFFF);
    tick(31'h7FFF_FFFF); tick(31'h7FFF_FFFF); tick(31'd3);
    // Index beyond a shrunken count is reduced.
    write_reg(CFG_DURATION, 32'd1);
    repeat (5) tick(31'd1);
    write_reg(CFG_COUNT, 32'd3);
    tick(31'd0);

    // Random phases over several settings; mostly ticks on a fully written table.
    counts = '{1, 2, 4, 7, 16, 5};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_COUNT, 32'(counts[ph]));
      write_reg(CFG_DURATION, (ph == 2) ? 32'h7FFF_FFFF : 32'($urandom_range(1, 150000)));
      write_reg(CFG_ENABLE, (ph == 4) ? 32'd0 : 32'd1);
      if (ph == 3) no_idle = 1'b1;
      if (ph == 1) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (1500) @(negedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 120; n++) begin
        if ($urandom_range(99) < 25)
          load_point(4'($urandom), rand_comp(), rand_comp(), rand_comp(), rand_comp());
        else
          tick(rand_step());
      end
      no_idle = 1'b0;
    end
    write_reg(CFG_ENABLE, 32'd1);

    drain();
    if (path_sb.n_errors == 0) begin
      $display("** catmull_rom_path_follower_top: PASSED **");
    end else begin
      $display("** catmull_rom_path_follower_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("** catmull_rom_path_follower_top: FAILED **");
    $finish;
  end
endmodule
